/* hw/rtl/cipp_pkg.sv */
// shared types, constants and helpers of the copy/insert patch parser
package cipp_pkg;

    // width of the decimal numbers read from the patch
    localparam int NUM_WIDTH = 32;
    // width of the position and length fields of a result
    localparam int OUT_NUM_W = 32;
    // width of a number times ten plus one digit
    localparam int MUL_W     = NUM_WIDTH + 4;
    // packed output tdata width, rounded up to whole bytes
    localparam int M_DATA_RAW = 8 + OUT_NUM_W + OUT_NUM_W + 2;
    localparam int M_DATA_W   = ((M_DATA_RAW + 7) / 8) * 8;
    localparam int M_DATA_PAD = M_DATA_W - M_DATA_RAW;

    // request kinds on the input side
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_END  = 1'b1;

    // result kinds
    localparam logic [1:0] K_INS  = 2'd0;
    localparam logic [1:0] K_COPY = 2'd1;
    localparam logic [1:0] K_DONE = 2'd2;
    localparam logic [1:0] K_ERR  = 2'd3;

    // error causes
    localparam logic [1:0] E_OPCODE   = 2'd0;
    localparam logic [1:0] E_NEWLINE  = 2'd1;
    localparam logic [1:0] E_TRUNC    = 2'd2;
    localparam logic [1:0] E_OVERFLOW = 2'd3;

    // characters of the patch syntax
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // parse phase, one-hot
    typedef enum logic [8:0] {
        PH_OP        = 9'b000000001,
        PH_I_SP      = 9'b000000010,
        PH_I_DIG     = 9'b000000100,
        PH_PAYLOAD   = 9'b000001000,
        PH_TRAILER   = 9'b000010000,
        PH_C_POS_SP  = 9'b000100000,
        PH_C_POS_DIG = 9'b001000000,
        PH_C_LEN_SP  = 9'b010000000,
        PH_C_LEN_DIG = 9'b100000000
    } t_phase;

    typedef logic [NUM_WIDTH-1:0] t_num;

    // low bits of a number, zero extended where the number is narrower
    function automatic logic [OUT_NUM_W-1:0] out_num(input t_num v);
        logic [NUM_WIDTH+OUT_NUM_W-1:0] w;
        w = {{OUT_NUM_W{1'b0}}, v};
        return w[OUT_NUM_W-1:0];
    endfunction

endpackage

/* hw/rtl/copy_insert_patch_parser.sv */
// copy/insert patch stream parser, one patch byte per request
// Takes one request per cycle while the result slot is free or leaving, and
// answers with at most one result in the cycle after; each byte only steps the
// parse phase and a multiply-by-ten accumulator. The single result register is
// refilled in the same cycle it is taken, so throughput is one request per cycle
// while the downstream side accepts. A patch byte makes an insert-byte result
// in payload, a copy command at the end of a copy record with non-zero length, or
// one error when a fault is first seen; later bytes are swallowed until the end
// request, which always yields done or error and rearms the parser.
module copy_insert_patch_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // patch_byte
    input  logic                           i_s_axis_tuser,  // req_type
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // insert_byte[7:0], copy_pos[39:8], copy_len[71:40], error_cause[73:72], zero pad
    output logic [cipp_pkg::M_DATA_W-1:0]  o_m_axis_tdata,
    output logic [1:0]                     o_m_axis_tuser   // kind
);

    // parser state
    cipp_pkg::t_phase r_phase, n_phase;
    cipp_pkg::t_num   r_accum, n_accum;
    cipp_pkg::t_num   r_held, n_held;
    cipp_pkg::t_num   r_left, n_left;
    logic             r_err, n_err;
    logic [1:0]       r_cause, n_cause;

    // result register
    logic             r_out_valid;
    logic [1:0]       r_kind, n_kind;
    logic [7:0]       r_ins, n_ins;
    logic [cipp_pkg::OUT_NUM_W-1:0] r_pos, n_pos;
    logic [cipp_pkg::OUT_NUM_W-1:0] r_len, n_len;
    logic [1:0]       r_ecause, n_ecause;
    logic             n_emit;

    logic s_accept;
    logic is_digit;
    logic [cipp_pkg::MUL_W-1:0] mul_sum;
    logic digit_ovf;
    logic [7:0] c;

    // handshake: take a request whenever the result slot is free or leaving
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign c               = i_s_axis_tdata;

    // digit accumulate: accum*10 + d, overflow when high bits are set
    assign is_digit  = (c >= cipp_pkg::CH_ZERO) && (c <= cipp_pkg::CH_NINE);
    assign mul_sum   = {1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0}
                     + {{(cipp_pkg::MUL_W-4){1'b0}}, 4'(c - cipp_pkg::CH_ZERO)};
    assign digit_ovf = |mul_sum[cipp_pkg::MUL_W-1:cipp_pkg::NUM_WIDTH];

    // next state and result
    always_comb begin
        n_phase  = r_phase;
        n_accum  = r_accum;
        n_held   = r_held;
        n_left   = r_left;
        n_err    = r_err;
        n_cause  = r_cause;
        n_emit   = 1'b0;
        n_kind   = cipp_pkg::K_DONE;
        n_ins    = '0;
        n_pos    = '0;
        n_len    = '0;
        n_ecause = '0;

        if (i_s_axis_tuser == cipp_pkg::REQ_END) begin
            n_emit = 1'b1;
            if (r_err) begin
                n_kind   = cipp_pkg::K_ERR;
                n_ecause = r_cause;
            end else if (r_phase != cipp_pkg::PH_OP) begin
                n_kind   = cipp_pkg::K_ERR;
                n_ecause = cipp_pkg::E_TRUNC;
            end
            n_phase = cipp_pkg::PH_OP;
            n_accum = '0;
            n_held  = '0;
            n_left  = '0;
            n_err   = 1'b0;
            n_cause = '0;
        end else if (!r_err) begin
            case (r_phase)
                cipp_pkg::PH_OP: begin
                    n_accum = '0;
                    n_held  = '0;
                    if (c == cipp_pkg::CH_I) begin
                        n_phase = cipp_pkg::PH_I_SP;
                    end else if (c == cipp_pkg::CH_C) begin
                        n_phase = cipp_pkg::PH_C_POS_SP;
                    end else begin
                        n_emit   = 1'b1;
                        n_kind   = cipp_pkg::K_ERR;
                        n_ecause = cipp_pkg::E_OPCODE;
                    end
                end
                cipp_pkg::PH_I_SP, cipp_pkg::PH_I_DIG: begin
                    if (r_phase == cipp_pkg::PH_I_SP && c == cipp_pkg::CH_SPACE) begin
                        n_phase = r_phase;
                    end else if (is_digit) begin
                        n_phase = cipp_pkg::PH_I_DIG;
                        if (digit_ovf) begin
                            n_emit   = 1'b1;
                            n_kind   = cipp_pkg::K_ERR;
                            n_ecause = cipp_pkg::E_OVERFLOW;
                        end else begin
                            n_accum = mul_sum[cipp_pkg::NUM_WIDTH-1:0];
                        end
                    end else if (c != cipp_pkg::CH_NL) begin
                        n_emit   = 1'b1;
                        n_kind   = cipp_pkg::K_ERR;
                        n_ecause = cipp_pkg::E_NEWLINE;
                    end else begin
                        n_left  = r_accum;
                        n_accum = '0;
                        n_phase = (r_accum != '0) ? cipp_pkg::PH_PAYLOAD
                                                  : cipp_pkg::PH_TRAILER;
                    end
                end
                cipp_pkg::PH_PAYLOAD: begin
                    n_left = r_left - cipp_pkg::t_num'(1);
                    if (r_left == cipp_pkg::t_num'(1)) begin
                        n_phase = cipp_pkg::PH_TRAILER;
                    end
                    n_emit = 1'b1;
                    n_kind = cipp_pkg::K_INS;
                    n_ins  = c;
                end
                cipp_pkg::PH_TRAILER: begin
                    if (c != cipp_pkg::CH_NL) begin
                        n_emit   = 1'b1;
                        n_kind   = cipp_pkg::K_ERR;
                        n_ecause = cipp_pkg::E_NEWLINE;
                    end else begin
                        n_phase = cipp_pkg::PH_OP;
                    end
                end
                cipp_pkg::PH_C_POS_SP, cipp_pkg::PH_C_POS_DIG: begin
                    if (r_phase == cipp_pkg::PH_C_POS_SP && c == cipp_pkg::CH_SPACE) begin
                        n_phase = r_phase;
                    end else if (is_digit) begin
                        n_phase = cipp_pkg::PH_C_POS_DIG;
                        if (digit_ovf) begin
                            n_emit   = 1'b1;
                            n_kind   = cipp_pkg::K_ERR;
                            n_ecause = cipp_pkg::E_OVERFLOW;
                        end else begin
                            n_accum = mul_sum[cipp_pkg::NUM_WIDTH-1:0];
                        end
                    end else begin
                        n_held  = r_accum;
                        n_accum = '0;
                        if (c == cipp_pkg::CH_SPACE) begin
                            n_phase = cipp_pkg::PH_C_LEN_SP;
                        end else if (c == cipp_pkg::CH_NL) begin
                            // length missing: reads as zero, copy dropped
                            n_phase = cipp_pkg::PH_OP;
                        end else begin
                            n_emit   = 1'b1;
                            n_kind   = cipp_pkg::K_ERR;
                            n_ecause = cipp_pkg::E_NEWLINE;
                        end
                    end
                end
                cipp_pkg::PH_C_LEN_SP, cipp_pkg::PH_C_LEN_DIG: begin
                    if (r_phase == cipp_pkg::PH_C_LEN_SP && c == cipp_pkg::CH_SPACE) begin
                        n_phase = r_phase;
                    end else if (is_digit) begin
                        n_phase = cipp_pkg::PH_C_LEN_DIG;
                        if (digit_ovf) begin
                            n_emit   = 1'b1;
                            n_kind   = cipp_pkg::K_ERR;
                            n_ecause = cipp_pkg::E_OVERFLOW;
                        end else begin
                            n_accum = mul_sum[cipp_pkg::NUM_WIDTH-1:0];
                        end
                    end else if (c == cipp_pkg::CH_NL) begin
                        n_phase = cipp_pkg::PH_OP;
                        n_accum = '0;
                        if (r_accum != '0) begin
                            n_emit = 1'b1;
                            n_kind = cipp_pkg::K_COPY;
                            n_pos  = cipp_pkg::out_num(r_held);
                            n_len  = cipp_pkg::out_num(r_accum);
                        end
                    end else begin
                        n_emit   = 1'b1;
                        n_kind   = cipp_pkg::K_ERR;
                        n_ecause = cipp_pkg::E_NEWLINE;
                    end
                end
                default: begin
                    n_phase = cipp_pkg::PH_OP;
                end
            endcase
            // any error result latches the sticky error
            if (n_emit && n_kind == cipp_pkg::K_ERR) begin
                n_err   = 1'b1;
                n_cause = n_ecause;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= cipp_pkg::PH_OP;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_phase     <= n_phase;
                r_err       <= n_err;
                r_out_valid <= n_emit;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // data registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_accum  <= n_accum;
            r_held   <= n_held;
            r_left   <= n_left;
            r_cause  <= n_cause;
            r_kind   <= n_kind;
            r_ins    <= n_ins;
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_ecause <= n_ecause;
        end
    end

    // result outputs
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_kind;
    assign o_m_axis_tdata  = {{cipp_pkg::M_DATA_PAD{1'b0}}, r_ecause, r_len, r_pos, r_ins};

`ifndef ASSERT_OFF
    // a copy command never carries a zero length
    a_copy_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == cipp_pkg::K_COPY) |-> (r_len != '0))
        else $error("copy command with zero length");

    // an end request rearms the parser
    a_end_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_axis_tuser == cipp_pkg::REQ_END)
            |=> (!r_err && r_phase == cipp_pkg::PH_OP && r_out_valid))
        else $error("end request did not rearm parser");

    // only insert results carry a payload byte
    a_ins_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != cipp_pkg::K_INS) |-> (r_ins == 8'd0))
        else $error("payload byte on non-insert result");

    // no byte result while the sticky error is held
    a_sticky_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && r_err && i_s_axis_tuser == cipp_pkg::REQ_BYTE) |=> !r_out_valid)
        else $error("result produced after error");
`endif

endmodule

/* tb/tb_top.sv */
// self-checking testbench of the copy/insert patch parser, directed table then random patches
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // one request of the input stream, with an optional typed-in result
    typedef struct packed {
        logic       req;
        logic [7:0] data;
        logic       chk_typed;
        logic       gives_res;
        logic [1:0] kind;
        logic [1:0] cause;
    } t_stim;

    // one result of the output stream
    typedef struct packed {
        logic [1:0]                     kind;
        logic [7:0]                     ins_byte;
        logic [cipp_pkg::OUT_NUM_W-1:0] pos;
        logic [cipp_pkg::OUT_NUM_W-1:0] len;
        logic [1:0]                     cause;
    } t_patch_res;

    localparam logic CHK_TYPED = 1'b1;
    localparam logic CHK_PRED  = 1'b0;
    localparam logic RES_ONE   = 1'b1;
    localparam logic RES_NONE  = 1'b0;

    localparam logic [5:0] PRED_ROW   = {CHK_PRED, RES_NONE, cipp_pkg::K_INS,
                                         cipp_pkg::E_OPCODE};
    localparam logic [5:0] TYPED_NONE = {CHK_TYPED, RES_NONE, cipp_pkg::K_INS,
                                         cipp_pkg::E_OPCODE};

    localparam longint unsigned NUM_MAX = (64'd1 << cipp_pkg::NUM_WIDTH) - 64'd1;

    localparam int N_RAND       = 1060;
    localparam int HOLD_AT      = 100;
    localparam int HOLD_LEN     = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 3000;

    // idling per phase: none, sender idle, receiver stalling, both
    localparam int TX_IDLE  [4] = '{0, 70, 0, 33};
    localparam int RX_STALL [4] = '{0, 0, 70, 33};

    // directed requests: end states, byte extremes, both records and their corner cases
    localparam int DIR_N = 29;
    localparam t_stim DIR_TAB [DIR_N] = '{
        {cipp_pkg::REQ_END,  8'hFF, CHK_TYPED, RES_ONE, cipp_pkg::K_DONE, cipp_pkg::E_OPCODE},
        {cipp_pkg::REQ_BYTE, 8'h00, CHK_TYPED, RES_ONE, cipp_pkg::K_ERR,  cipp_pkg::E_OPCODE},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_I,           TYPED_NONE},
        {cipp_pkg::REQ_END,  8'h00, CHK_TYPED, RES_ONE, cipp_pkg::K_ERR,  cipp_pkg::E_OPCODE},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_I,           PRED_ROW},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_SPACE,       PRED_ROW},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_ZERO + 8'd2, PRED_ROW},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_NL,          PRED_ROW},
        {cipp_pkg::REQ_BYTE, 8'h00,                    PRED_ROW},
        {cipp_pkg::REQ_BYTE, 8'hFF,                    PRED_ROW},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_NL,          PRED_ROW},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_C,           PRED_ROW},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_NL,          TYPED_NONE},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_C,           PRED_ROW},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_ZERO + 8'd5, PRED_ROW},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_SPACE,       PRED_ROW},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_NINE,        PRED_ROW},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_NL,          PRED_ROW},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_I,           PRED_ROW},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_ZERO,        PRED_ROW},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_NL,          PRED_ROW},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_NL,          TYPED_NONE},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_I,           PRED_ROW},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_ZERO + 8'd1, PRED_ROW},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_SPACE, CHK_TYPED, RES_ONE, cipp_pkg::K_ERR,
         cipp_pkg::E_NEWLINE},
        {cipp_pkg::REQ_END,  8'h5A, CHK_TYPED, RES_ONE, cipp_pkg::K_ERR,  cipp_pkg::E_NEWLINE},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_C,           PRED_ROW},
        {cipp_pkg::REQ_BYTE, cipp_pkg::CH_ZERO + 8'd7, PRED_ROW},
        {cipp_pkg::REQ_END,  8'hA5, CHK_TYPED, RES_ONE, cipp_pkg::K_ERR,  cipp_pkg::E_TRUNC}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [7:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [cipp_pkg::M_DATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;

    t_stim      patch_q [$];
    logic [7:0] rec_q [$];
    t_patch_res exp_q [$];
    int acc_n        = 0;
    int fail_n       = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    // parser state as predicted
    cipp_pkg::t_phase parse_ph = cipp_pkg::PH_OP;
    longint unsigned  num_acc  = 0;
    longint unsigned  held_pos = 0;
    longint unsigned  ins_left = 0;
    logic             err_seen = 1'b0;
    logic [1:0]       err_cause = cipp_pkg::E_OPCODE;

    copy_insert_patch_parser u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // patch_byte
        .i_s_axis_tuser  (s_tuser),   // req_type
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        // insert_byte, copy_pos, copy_len, error_cause, zero pad
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)    // kind
    );

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // reset, once at the start
    initial begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // latch an error and build its result
    function automatic bit flag_error(input logic [1:0] cause, output t_patch_res r);
        err_seen  = 1'b1;
        err_cause = cause;
        r         = '0;
        r.kind    = cipp_pkg::K_ERR;
        r.cause   = cause;
        return 1'b1;
    endfunction

    // one decimal digit into the number, 0 on overflow
    function automatic bit push_digit(input logic [7:0] c);
        longint unsigned d;
        d = longint'(c - cipp_pkg::CH_ZERO);
        if (num_acc > (NUM_MAX - d) / 10) return 1'b0;
        num_acc = num_acc * 10 + d;
        return 1'b1;
    endfunction

    function automatic bit is_dig(input logic [7:0] c);
        return (c >= cipp_pkg::CH_ZERO) && (c <= cipp_pkg::CH_NINE);
    endfunction

    // copy record complete, zero length gives nothing
    function automatic bit close_copy(output t_patch_res r);
        longint unsigned n;
        n        = num_acc;
        r        = '0;
        parse_ph = cipp_pkg::PH_OP;
        num_acc  = 0;
        if (n == 0) return 1'b0;
        r.kind = cipp_pkg::K_COPY;
        r.pos  = held_pos[cipp_pkg::OUT_NUM_W-1:0];
        r.len  = n[cipp_pkg::OUT_NUM_W-1:0];
        return 1'b1;
    endfunction

    // predicted parser step for one request, 1 when it yields a result
    function automatic bit step_parser(input logic req, input logic [7:0] c,
                                       output t_patch_res r);
        r = '0;
        if (req == cipp_pkg::REQ_END) begin
            if (err_seen) begin
                r.kind  = cipp_pkg::K_ERR;
                r.cause = err_cause;
            end else if (parse_ph != cipp_pkg::PH_OP) begin
                r.kind  = cipp_pkg::K_ERR;
                r.cause = cipp_pkg::E_TRUNC;
            end else begin
                r.kind = cipp_pkg::K_DONE;
            end
            parse_ph  = cipp_pkg::PH_OP;
            num_acc   = 0;
            held_pos  = 0;
            ins_left  = 0;
            err_seen  = 1'b0;
            err_cause = cipp_pkg::E_OPCODE;
            return 1'b1;
        end
        if (err_seen) return 1'b0;
        case (parse_ph)
            cipp_pkg::PH_OP: begin
                num_acc  = 0;
                held_pos = 0;
                if (c == cipp_pkg::CH_I) begin
                    parse_ph = cipp_pkg::PH_I_SP;
                    return 1'b0;
                end
                if (c == cipp_pkg::CH_C) begin
                    parse_ph = cipp_pkg::PH_C_POS_SP;
                    return 1'b0;
                end
                return flag_error(cipp_pkg::E_OPCODE, r);
            end
            cipp_pkg::PH_I_SP, cipp_pkg::PH_I_DIG: begin
                if (parse_ph == cipp_pkg::PH_I_SP && c == cipp_pkg::CH_SPACE) return 1'b0;
                if (is_dig(c)) begin
                    parse_ph = cipp_pkg::PH_I_DIG;
                    if (!push_digit(c)) return flag_error(cipp_pkg::E_OVERFLOW, r);
                    return 1'b0;
                end
                if (c != cipp_pkg::CH_NL) return flag_error(cipp_pkg::E_NEWLINE, r);
                ins_left = num_acc;
                num_acc  = 0;
                parse_ph = (ins_left != 0) ? cipp_pkg::PH_PAYLOAD : cipp_pkg::PH_TRAILER;
                return 1'b0;
            end
            cipp_pkg::PH_PAYLOAD: begin
                ins_left = ins_left - 1;
                if (ins_left == 0) parse_ph = cipp_pkg::PH_TRAILER;
                r.kind     = cipp_pkg::K_INS;
                r.ins_byte = c;
                return 1'b1;
            end
            cipp_pkg::PH_TRAILER: begin
                if (c != cipp_pkg::CH_NL) return flag_error(cipp_pkg::E_NEWLINE, r);
                parse_ph = cipp_pkg::PH_OP;
                return 1'b0;
            end
            cipp_pkg::PH_C_POS_SP, cipp_pkg::PH_C_POS_DIG: begin
                if (parse_ph == cipp_pkg::PH_C_POS_SP && c == cipp_pkg::CH_SPACE) return 1'b0;
                if (is_dig(c)) begin
                    parse_ph = cipp_pkg::PH_C_POS_DIG;
                    if (!push_digit(c)) return flag_error(cipp_pkg::E_OVERFLOW, r);
                    return 1'b0;
                end
                held_pos = num_acc;
                num_acc  = 0;
                if (c == cipp_pkg::CH_SPACE) begin
                    parse_ph = cipp_pkg::PH_C_LEN_SP;
                    return 1'b0;
                end
                if (c == cipp_pkg::CH_NL) return close_copy(r);
                return flag_error(cipp_pkg::E_NEWLINE, r);
            end
            cipp_pkg::PH_C_LEN_SP, cipp_pkg::PH_C_LEN_DIG: begin
                if (parse_ph == cipp_pkg::PH_C_LEN_SP && c == cipp_pkg::CH_SPACE) return 1'b0;
                if (is_dig(c)) begin
                    parse_ph = cipp_pkg::PH_C_LEN_DIG;
                    if (!push_digit(c)) return flag_error(cipp_pkg::E_OVERFLOW, r);
                    return 1'b0;
                end
                if (c == cipp_pkg::CH_NL) return close_copy(r);
                return flag_error(cipp_pkg::E_NEWLINE, r);
            end
            default: begin
                parse_ph = cipp_pkg::PH_OP;
                return 1'b0;
            end
        endcase
    endfunction

    // stimulus building helpers
    function automatic void push_item(input logic req, input logic [7:0] data);
        patch_q.insert(patch_q.size(), {req, data, PRED_ROW});
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        rec_q.insert(rec_q.size(), b);
    endfunction

    function automatic void add_spaces();
        repeat ($urandom_range(2)) add_byte(cipp_pkg::CH_SPACE);
    endfunction

    function automatic void add_decimal(input longint unsigned v, input int zeros);
        logic [7:0] dig [$];
        repeat (zeros) add_byte(cipp_pkg::CH_ZERO);
        do begin
            dig.push_front(cipp_pkg::CH_ZERO + 8'(v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (dig[k]) add_byte(dig[k]);
    endfunction

    // a copy number: missing, small, wide, at the limit, past it, or a raw digit run
    function automatic void add_field();
        int m;
        longint unsigned v;
        m = $urandom_range(9);
        case (m)
            0: return;
            1, 2: v = $urandom_range(99);
            3, 4: v = {$urandom, $urandom} & NUM_MAX;
            5: v = NUM_MAX;
            6: v = NUM_MAX + 1;
            7: v = 0;
            8: begin
                repeat ($urandom_range(12, 1))
                    add_byte(cipp_pkg::CH_ZERO + 8'($urandom_range(9)));
                return;
            end
            default: v = $urandom_range(9);
        endcase
        add_decimal(v, ($urandom_range(3) == 0) ? $urandom_range(2) : 0);
    endfunction

    // build the whole request list: directed table, then random patches
    initial begin : build_patch
        int r;
        int m;
        int n;
        int idx;
        int mode;
        for (int i = 0; i < DIR_N; i++) patch_q.insert(patch_q.size(), DIR_TAB[i]);
        while (patch_q.size() < DIR_N + N_RAND) begin
            r = $urandom_range(99);
            rec_q.delete();
            if (r < 40) begin
                // insert record
                add_byte(cipp_pkg::CH_I);
                add_spaces();
                m = $urandom_range(99);
                n = 0;
                if (m < 10) begin
                    n = 0;
                end else if (m < 15) begin
                    repeat (11) add_byte(cipp_pkg::CH_NINE);
                end else if (m < 22) begin
                    n = $urandom_range(40, 9);
                    add_decimal(n, 0);
                end else begin
                    n = $urandom_range(8);
                    add_decimal(n, ($urandom_range(4) == 0) ? 1 : 0);
                end
                add_byte(cipp_pkg::CH_NL);
                repeat (n) add_byte(8'($urandom));
                add_byte(cipp_pkg::CH_NL);
            end else if (r < 75) begin
                // copy record
                add_byte(cipp_pkg::CH_C);
                add_spaces();
                add_field();
                if ($urandom_range(99) < 85) begin
                    add_byte(cipp_pkg::CH_SPACE);
                    add_spaces();
                    add_field();
                    if ($urandom_range(19) == 0) add_byte(cipp_pkg::CH_SPACE);
                end
                add_byte(cipp_pkg::CH_NL);
            end else if (r < 82) begin
                // noise bytes
                repeat ($urandom_range(3, 1)) add_byte(8'($urandom));
            end else begin
                push_item(cipp_pkg::REQ_END, 8'($urandom));
                continue;
            end
            // mostly well formed, else one byte replaced, dropped, or cut short
            mode = $urandom_range(99);
            idx  = $urandom_range(rec_q.size() - 1);
            if (mode >= 94 && rec_q.size() > 1) begin
                idx   = $urandom_range(rec_q.size() - 1, 1);
                rec_q = rec_q[0:idx-1];
            end else if (mode >= 88) begin
                rec_q.delete(idx);
            end else if (mode >= 80) begin
                rec_q[idx] = 8'($urandom);
            end
            foreach (rec_q[k]) push_item(cipp_pkg::REQ_BYTE, rec_q[k]);
            if (mode >= 94) push_item(cipp_pkg::REQ_END, 8'($urandom));
        end
        push_item(cipp_pkg::REQ_END, 8'($urandom));
    end

    // sender: phases of idling, pause to drain at each phase change, then final drain
    initial begin : drive_patch
        int ph;
        int prev_ph;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = cipp_pkg::REQ_BYTE;
        prev_ph  = 0;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        for (int di = 0; di < patch_q.size(); di++) begin
            ph = (di < DIR_N) ? 0 : ((di - DIR_N) * 4) / (patch_q.size() - DIR_N);
            if (ph != prev_ph) begin
                s_tvalid <= 1'b0;
                @(negedge clk);
                while (!(acc_n == di && exp_q.size() == 0)) @(negedge clk);
                prev_ph = ph;
            end
            tx_idle_pct  = TX_IDLE[ph];
            rx_stall_pct = RX_STALL[ph];
            while ($urandom_range(99) < tx_idle_pct) begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= patch_q[di].data;
            s_tuser  <= patch_q[di].req;
            @(posedge clk);
            while (!s_tready) @(posedge clk);
            @(negedge clk);
        end
        s_tvalid <= 1'b0;
        while (!(acc_n == patch_q.size() && exp_q.size() == 0)) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_n == 0) begin
            $display("copy_insert_patch_parser regression: pass");
        end else begin
            $display("copy_insert_patch_parser regression: fail");
        end
        $finish;
    end

    // receiver: random stalls, and one long hold-off while the sender keeps offering
    initial begin : drive_ready
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (!held && acc_n >= DIR_N + HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    function automatic void cmp_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_n++;
        end
    endfunction

    // predict on each accepted request, check each accepted result
    always @(posedge clk) begin : check_results
        t_patch_res want;
        t_patch_res got;
        t_stim      it;
        bit         has;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                it  = patch_q[acc_n];
                has = step_parser(it.req, it.data, want);
                if (it.chk_typed) begin
                    has        = it.gives_res;
                    want       = '0;
                    want.kind  = it.kind;
                    want.cause = it.cause;
                end
                if (has) exp_q.insert(exp_q.size(), want);
                acc_n++;
            end
            if (m_tvalid && m_tready) begin
                got.kind     = m_tuser;
                got.ins_byte = m_tdata[7:0];
                got.pos      = m_tdata[8 +: cipp_pkg::OUT_NUM_W];
                got.len      = m_tdata[8 + cipp_pkg::OUT_NUM_W +: cipp_pkg::OUT_NUM_W];
                got.cause    = m_tdata[8 + 2 * cipp_pkg::OUT_NUM_W +: 2];
                if (exp_q.size() == 0) begin
                    $error("result with nothing expected: kind %0d", got.kind);
                    fail_n++;
                end else begin
                    want = exp_q.pop_front();
                    cmp_field("kind", want.kind, got.kind);
                    cmp_field("insert_byte", want.ins_byte, got.ins_byte);
                    cmp_field("copy_pos", want.pos, got.pos);
                    cmp_field("copy_len", want.len, got.len);
                    cmp_field("error_cause", want.cause, got.cause);
                end
            end
        end
    end

    // watchdog on cycles with no request or result moving
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("copy_insert_patch_parser regression: fail");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/cipp_pkg.sv
hw/rtl/copy_insert_patch_parser.sv
tb/tb_top.sv
